// ===== rtl/ist_pkg.sv =====
// ----------------------------------------------------------------------------
// ist_pkg : shared types and codes for the integer set table
// Operation codes, field widths and the scan status flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ist_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CountW = 5;
  localparam int unsigned OutW   = 8;

  typedef enum logic [KindW-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_TEST   = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic hit;
    logic free;
  } scan_flags_t;

endpackage

`default_nettype wire

// ===== rtl/ist_ram.sv =====
// ----------------------------------------------------------------------------
// ist_ram : generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ist_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire                                    clk,
  input  wire                                    we,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                       wdata,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/ist_scan_unit.sv =====
// ----------------------------------------------------------------------------
// ist_scan_unit : shared slot comparator
// Compares one slot per beat against the key and keeps the first match
// and the first free slot seen since the last clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ist_scan_unit #(
  parameter int unsigned AW = 4
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           clear,
  input  wire                           strobe,
  input  wire  [AW-1:0]                 slot_idx,
  input  wire                           slot_valid,
  input  wire  [ist_pkg::ValueW-1:0]    slot_value,
  input  wire  [ist_pkg::ValueW-1:0]    key,
  output ist_pkg::scan_flags_t          flags,
  output logic [AW-1:0]                 hit_idx,
  output logic [AW-1:0]                 free_idx
);

  logic          hit_r, hit_nxt;
  logic          free_r, free_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt;
  logic [AW-1:0] free_idx_r, free_idx_nxt;
  logic          match;

  assign match = slot_valid && (slot_value == key);

  always_comb begin
    hit_nxt      = hit_r;
    free_nxt     = free_r;
    hit_idx_nxt  = hit_idx_r;
    free_idx_nxt = free_idx_r;
    if (clear) begin
      hit_nxt  = 1'b0;
      free_nxt = 1'b0;
    end else if (strobe) begin
      if (match && !hit_r) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = slot_idx;
      end
      if (!slot_valid && !free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = slot_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else begin
      hit_r  <= hit_nxt;
      free_r <= free_nxt;
    end
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
  end

  assign flags.hit  = hit_r;
  assign flags.free = free_r;
  assign hit_idx    = hit_idx_r;
  assign free_idx   = free_idx_r;

endmodule

`default_nettype wire

// ===== rtl/integer_set_table.sv =====
// ----------------------------------------------------------------------------
// integer_set_table : bounded set of signed 32-bit integers
// Add, remove or test one value per input beat; one result beat each.
//
// Input channel: in_tdata carries the value, in_tuser the operation
// (add, remove, test; the spare code acts as a test). Result channel:
// out_tdata carries was_present, member_count, is_empty and overflow.
// Each operation sweeps all CAPACITY slots through one comparator, fed
// by the slot RAM's single read port: an idle state to accept, a scan
// state over every slot, an update state and a deliver state that loads
// the result register, one item at a time.
// in_tready is high only while the block waits for an item; the next item
// may be accepted while the previous result still waits to be taken.
// If the receiver stalls, the finished result holds in the output register
// and the following item stops before delivery until it is taken.
// After reset a clearing pass over all CAPACITY slots zeroes the slot valid
// marks; no item is accepted during it. The set is then empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module integer_set_table #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [ist_pkg::ValueW-1:0]   in_tdata,   // item_value
  input  wire  [ist_pkg::KindW-1:0]    in_tuser,   // kind
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [ist_pkg::OutW-1:0]     out_tdata   // was_present, member_count[4:0],
                                                   // is_empty, overflow
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    ST_CLEAR   = 5'b00001,
    ST_IDLE    = 5'b00010,
    ST_SCAN    = 5'b00100,
    ST_UPDATE  = 5'b01000,
    ST_DELIVER = 5'b10000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic                        pend_r, pend_nxt;
  logic [AW-1:0]               pend_idx_r, pend_idx_nxt;
  logic [CW-1:0]               members_r, members_nxt;
  ist_pkg::kind_t              kind_r, kind_nxt;
  logic [ist_pkg::ValueW-1:0]  key_r, key_nxt;
  logic                        hit_r, hit_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        out_tvalid_r, out_tvalid_nxt;
  logic [ist_pkg::OutW-1:0]    out_tdata_r, out_tdata_nxt;

  logic                        val_we, vld_we, vld_wdata;
  logic [AW-1:0]               waddr, raddr;
  logic [ist_pkg::ValueW-1:0]  rd_value;
  logic                        rd_valid;
  logic                        scan_clear;
  ist_pkg::scan_flags_t        flags;
  logic [AW-1:0]               hit_idx, free_idx;
  logic [CW+4:0]               count_wide;

  assign in_tready = (state_r == ST_IDLE);
  assign raddr     = idx_r[AW-1:0];
  assign count_wide = {5'd0, members_r};

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    members_nxt    = members_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    hit_nxt        = hit_r;
    ovf_nxt        = ovf_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    val_we         = 1'b0;
    vld_we         = 1'b0;
    vld_wdata      = 1'b0;
    waddr          = idx_r[AW-1:0];
    scan_clear     = 1'b0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        vld_we = 1'b1;
        idx_nxt = idx_r + CW'(1);
        if (idx_r[AW-1:0] == AW'(CAPACITY - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt   = ist_pkg::kind_t'(in_tuser);
          key_nxt    = in_tdata;
          idx_nxt    = '0;
          scan_clear = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_r == CW'(CAPACITY)) begin
          state_nxt = ST_UPDATE;
        end else begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[AW-1:0];
          idx_nxt      = idx_r + CW'(1);
        end
      end
      ST_UPDATE: begin
        hit_nxt = flags.hit;
        ovf_nxt = 1'b0;
        unique case (kind_r)
          ist_pkg::KIND_ADD: begin
            if (!flags.hit) begin
              if (flags.free && (members_r < CW'(CAPACITY))) begin
                val_we      = 1'b1;
                vld_we      = 1'b1;
                vld_wdata   = 1'b1;
                waddr       = free_idx;
                members_nxt = members_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
          end
          ist_pkg::KIND_REMOVE: begin
            if (flags.hit) begin
              vld_we = 1'b1;
              waddr  = hit_idx;
              if (members_r != '0) begin
                members_nxt = members_r - CW'(1);
              end
            end
          end
          default: begin
          end
        endcase
        state_nxt = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {ovf_r, (members_r == '0), count_wide[4:0], hit_r};
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      idx_r        <= '0;
      pend_r       <= 1'b0;
      members_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      pend_r       <= pend_nxt;
      members_r    <= members_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    pend_idx_r  <= pend_idx_nxt;
    kind_r      <= kind_nxt;
    key_r       <= key_nxt;
    hit_r       <= hit_nxt;
    ovf_r       <= ovf_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  ist_ram #(
    .WIDTH (ist_pkg::ValueW),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (waddr),
    .wdata (key_r),
    .raddr (raddr),
    .rdata (rd_value)
  );

  ist_ram #(
    .WIDTH (1),
    .DEPTH (CAPACITY)
  ) u_valid_ram (
    .clk   (clk),
    .we    (vld_we),
    .waddr (waddr),
    .wdata (vld_wdata),
    .raddr (raddr),
    .rdata (rd_valid)
  );

  ist_scan_unit #(
    .AW (AW)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (scan_clear),
    .strobe     (pend_r),
    .slot_idx   (pend_idx_r),
    .slot_valid (rd_valid),
    .slot_value (rd_value),
    .key        (key_r),
    .flags      (flags),
    .hit_idx    (hit_idx),
    .free_idx   (free_idx)
  );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench : self-checking bench for integer_set_table
// Queued add/remove/test beats are driven in random bursts against a
// receiver that stalls on its own pattern. Each accepted beat is run through
// a local model of the bounded set, and every result beat is checked
// field by field against the oldest expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned SetCap        = 16;
  localparam int unsigned RandomOps     = 600;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned MaxReported   = 50;

  typedef struct {
    ist_pkg::kind_t kind;
    logic [31:0]    value;
  } set_op_t;

  // matches out_tdata, lowest bit last
  typedef struct packed {
    logic       overflow;
    logic       is_empty;
    logic [4:0] member_count;
    logic       was_present;
  } set_result_t;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [ist_pkg::ValueW-1:0] in_tdata   = '0;
  logic [ist_pkg::KindW-1:0]  in_tuser   = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [ist_pkg::OutW-1:0]   out_tdata;

  set_op_t     pending_ops[$];
  set_result_t expected_results[$];

  // model of the set contents
  logic [31:0]         set_slot_val [SetCap];
  logic [SetCap-1:0]   set_slot_used = '0;
  int unsigned         set_members   = 0;

  int unsigned fail_count  = 0;
  int unsigned in_beats    = 0;
  int unsigned out_beats   = 0;
  int unsigned total_ops   = 0;
  int unsigned idle_cycles = 0;
  logic        in_took     = 1'b0;

  int unsigned gap_left   = 0;
  int unsigned burst_left = 4;
  logic        rdy_level  = 1'b1;
  int unsigned rdy_left   = 10;

  integer_set_table #(
    .CAPACITY (SetCap)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic set_result_t predict_set_op(set_op_t op);
    int          hit;
    int          free_idx;
    set_result_t r;
    hit      = -1;
    free_idx = -1;
    for (int i = 0; i < SetCap; i++) begin
      if (hit < 0 && set_slot_used[i] && set_slot_val[i] == op.value) hit = i;
      if (free_idx < 0 && !set_slot_used[i]) free_idx = i;
    end
    r.overflow = 1'b0;
    case (op.kind)
      ist_pkg::KIND_ADD: begin
        if (hit < 0) begin
          if (free_idx >= 0 && set_members < SetCap) begin
            set_slot_val[free_idx]  = op.value;
            set_slot_used[free_idx] = 1'b1;
            set_members++;
          end else begin
            r.overflow = 1'b1;
          end
        end
      end
      ist_pkg::KIND_REMOVE: begin
        if (hit >= 0) begin
          set_slot_used[hit] = 1'b0;
          if (set_members > 0) set_members--;
        end
      end
      default: ;
    endcase
    r.was_present  = (hit >= 0);
    r.member_count = set_members[4:0];
    r.is_empty     = (set_members == 0);
    return r;
  endfunction

  task automatic report_error(input string msg);
    if (fail_count < MaxReported) $display("ERROR result beat %0d: %s", out_beats, msg);
    fail_count++;
  endtask

  task automatic queue_op(input ist_pkg::kind_t k, input logic [31:0] v);
    set_op_t op;
    op.kind  = k;
    op.value = v;
    pending_ops.push_back(op);
  endtask

  function automatic ist_pkg::kind_t pick_kind(input bit grow);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < (grow ? 60 : 25)) return ist_pkg::KIND_ADD;
    if (r < 85)               return ist_pkg::KIND_REMOVE;
    if (r < 96)               return ist_pkg::KIND_TEST;
    return ist_pkg::KIND_SPARE;
  endfunction

  // scoreboard: check result beats, then predict accepted input beats
  always @(posedge clk) begin
    set_result_t got;
    set_result_t want;
    set_op_t     op;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        got = set_result_t'(out_tdata);
        if (expected_results.size() == 0) begin
          report_error($sformatf("unexpected result %0h", out_tdata));
        end else begin
          want = expected_results.pop_front();
          if (got.was_present !== want.was_present)
            report_error($sformatf("was_present exp %0b got %0b",
                                   want.was_present, got.was_present));
          if (got.member_count !== want.member_count)
            report_error($sformatf("member_count exp %0d got %0d",
                                   want.member_count, got.member_count));
          if (got.is_empty !== want.is_empty)
            report_error($sformatf("is_empty exp %0b got %0b",
                                   want.is_empty, got.is_empty));
          if (got.overflow !== want.overflow)
            report_error($sformatf("overflow exp %0b got %0b",
                                   want.overflow, got.overflow));
        end
        out_beats++;
      end
      if (in_tvalid && in_tready) begin
        op.kind  = ist_pkg::kind_t'(in_tuser);
        op.value = in_tdata;
        expected_results.push_back(predict_set_op(op));
        in_beats++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // sender: bursts of beats with random gaps
  always @(negedge clk) begin
    logic        nxt_valid;
    set_op_t     op;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_took)) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_ops.size() > 0) begin
        op        = pending_ops.pop_front();
        nxt_valid = 1'b1;
        in_tdata  <= op.value;
        in_tuser  <= op.kind;
        burst_left--;
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 12);
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  // receiver: alternating ready and stall stretches
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (rdy_left == 0) begin
        rdy_level = !rdy_level;
        rdy_left  = rdy_level ? $urandom_range(1, 60) : $urandom_range(1, 25);
      end
      rdy_left--;
      out_tready <= rdy_level;
    end
  end

  initial begin
    logic [31:0] value_pool [20];
    bit          grow;

    // directed: extremes, duplicate, absent remove, spare code, fill, overflow
    queue_op(ist_pkg::KIND_TEST,   32'h0000_0000);
    queue_op(ist_pkg::KIND_ADD,    32'h8000_0000);
    queue_op(ist_pkg::KIND_ADD,    32'h7FFF_FFFF);
    queue_op(ist_pkg::KIND_ADD,    32'h8000_0000);
    queue_op(ist_pkg::KIND_REMOVE, 32'h0000_0005);
    queue_op(ist_pkg::KIND_SPARE,  32'h7FFF_FFFF);
    queue_op(ist_pkg::KIND_REMOVE, 32'h7FFF_FFFF);
    queue_op(ist_pkg::KIND_ADD,    32'hFFFF_FFFF);
    queue_op(ist_pkg::KIND_ADD,    32'h0000_0000);
    for (int i = 1; i <= 13; i++) queue_op(ist_pkg::KIND_ADD, 32'(i));
    queue_op(ist_pkg::KIND_ADD,    32'h5555_5555);
    queue_op(ist_pkg::KIND_TEST,   32'hFFFF_FFFF);
    queue_op(ist_pkg::KIND_REMOVE, 32'h8000_0000);

    // random: a pool a little larger than the table so it fills and drains
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7FFF_FFFF;
    value_pool[4] = 32'h5555_5555;
    value_pool[5] = 32'hAAAA_AAAA;
    for (int i = 6; i < 20; i++) value_pool[i] = $urandom;
    for (int n = 0; n < RandomOps; n++) begin
      grow = ((n / 60) % 2) == 0;
      queue_op(pick_kind(grow),
               ($urandom_range(0, 3) == 0) ? $urandom : value_pool[$urandom_range(0, 19)]);
    end
    total_ops = pending_ops.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (in_beats < total_ops) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (SetCap + 8) @(posedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ist_pkg.sv
rtl/ist_ram.sv
rtl/ist_scan_unit.sv
rtl/integer_set_table.sv
tb/sv/testbench.sv
